// ----- rtl/oed_pkg.sv -----
// Shared constants and types for the occupation excitation diff unit.
package oed_pkg;

  // Default number of 64-bit chunks in one determinant pair.
  localparam int unsigned NumChunksDefault = 4;

  // Fixed widths of the item fields.
  localparam int unsigned ChunkW = 64;
  localparam int unsigned BitIdxW = $clog2(ChunkW);
  localparam int unsigned PosW = 8;
  localparam int unsigned CountW = 2;

  // Most differing orbitals kept on one side, and the count that flags overflow.
  localparam logic [CountW-1:0] MaxFound = 2'd2;
  localparam logic [CountW-1:0] OverflowCount = 2'd3;

  // Result of one step of the shared lowest-set-bit extractor.
  typedef struct packed {
    logic              nonzero;
    logic [BitIdxW-1:0] index;
    logic [ChunkW-1:0] low_bit;
    logic              below_parity;
  } ext_res_t;

endpackage

// ----- rtl/occupation_excitation_diff_unit.sv -----
// Top level of the occupation excitation diff unit: chunk sequencer and result register.
//
//   Channel | Direction | Handshake                | Payload
//   in      | input     | in_valid_i / in_stall_o  | left_chunk_i, right_chunk_i, last_chunk_i
//   out     | output    | out_valid_o / out_stall_i| diff_count_o, left/right_first/second_o,
//           |           |                          | odd_permutation_o
//
// A chunk goes from idle through a left scan (one step per left-only bit taken, then a final
// step), a right scan in the same manner and a finish state; the single extractor pulls one differing bit per cycle.
// A chunk whose left side overflows skips the right scan.
// A chunk after overflow or past the chunk limit goes from idle straight to the finish state.
// Reset clears the pair state and empties the result register.
// A last chunk whose result register is still held by out_stall_i waits until it drains.
module occupation_excitation_diff_unit #(
  parameter int unsigned NumChunks = oed_pkg::NumChunksDefault
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [oed_pkg::ChunkW-1:0]  left_chunk_i,
  input  logic [oed_pkg::ChunkW-1:0]  right_chunk_i,
  input  logic                        last_chunk_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [oed_pkg::CountW-1:0]  diff_count_o,
  output logic [oed_pkg::PosW-1:0]    left_first_o,
  output logic [oed_pkg::PosW-1:0]    left_second_o,
  output logic [oed_pkg::PosW-1:0]    right_first_o,
  output logic [oed_pkg::PosW-1:0]    right_second_o,
  output logic                        odd_permutation_o
);

  localparam int unsigned ChunkPosW = $clog2(NumChunks + 1);

  typedef enum logic [1:0] {
    StIdle,
    StScanLeft,
    StScanRight,
    StFinish
  } state_e;

  state_e                      state_q, state_d;
  logic [oed_pkg::ChunkW-1:0]  left_q, left_d;
  logic [oed_pkg::ChunkW-1:0]  right_q, right_d;
  logic [oed_pkg::ChunkW-1:0]  work_q, work_d;
  logic                        last_q, last_d;
  logic [ChunkPosW-1:0]        chunk_q, chunk_d;
  logic                        left_below_q, left_below_d;
  logic                        right_below_q, right_below_d;
  logic [oed_pkg::CountW-1:0]  left_found_q, left_found_d;
  logic [oed_pkg::CountW-1:0]  right_found_q, right_found_d;
  logic [oed_pkg::PosW-1:0]    pos_q [4];
  logic [oed_pkg::PosW-1:0]    pos_d [4];
  logic                        parity_q, parity_d;
  logic                        ovf_q, ovf_d;

  logic                        out_valid_q, out_valid_d;
  logic [oed_pkg::CountW-1:0]  diff_count_q, diff_count_d;
  logic [oed_pkg::PosW-1:0]    out_pos_q [4];
  logic [oed_pkg::PosW-1:0]    out_pos_d [4];
  logic                        odd_q, odd_d;

  logic [oed_pkg::ChunkW-1:0]  ext_side;
  oed_pkg::ext_res_t           ext;
  logic [oed_pkg::PosW-1:0]    chunk_wide;
  logic [oed_pkg::PosW-1:0]    found_pos;
  logic                        in_accept;
  logic                        out_free;

  // The one shared extractor serves both sides in turn.
  assign ext_side = (state_q == StScanRight) ? right_q : left_q;

  oed_extract u_extract (
    .work_i (work_q),
    .side_i (ext_side),
    .res_o  (ext)
  );

  // Orbital index of the extracted bit, kept modulo 256.
  assign chunk_wide = oed_pkg::PosW'(chunk_q);
  assign found_pos  = {chunk_wide[1:0], ext.index};

  assign in_stall_o = (state_q != StIdle);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  // Sequencer: one extraction step per cycle, then the result hand-off.
  always_comb begin
    state_d       = state_q;
    left_d        = left_q;
    right_d       = right_q;
    work_d        = work_q;
    last_d        = last_q;
    chunk_d       = chunk_q;
    left_below_d  = left_below_q;
    right_below_d = right_below_q;
    left_found_d  = left_found_q;
    right_found_d = right_found_q;
    pos_d         = pos_q;
    parity_d      = parity_q;
    ovf_d         = ovf_q;
    out_valid_d   = out_valid_q && out_stall_i;
    diff_count_d  = diff_count_q;
    out_pos_d     = out_pos_q;
    odd_d         = odd_q;

    case (state_q)
      StIdle: begin
        if (in_accept) begin
          left_d  = left_chunk_i;
          right_d = right_chunk_i;
          last_d  = last_chunk_i;
          work_d  = left_chunk_i & ~right_chunk_i;
          if (!ovf_q && (chunk_q < ChunkPosW'(NumChunks))) begin
            state_d = StScanLeft;
          end else begin
            state_d = StFinish;
          end
        end
      end
      StScanLeft: begin
        if (!ext.nonzero) begin
          work_d  = right_q & ~left_q;
          state_d = StScanRight;
        end else if (left_found_q == oed_pkg::MaxFound) begin
          ovf_d   = 1'b1;
          chunk_d = chunk_q + ChunkPosW'(1);
          state_d = StFinish;
        end else begin
          pos_d[{1'b0, left_found_q[0]}] = found_pos;
          left_found_d = left_found_q + oed_pkg::CountW'(1);
          parity_d     = parity_q ^ left_below_q ^ ext.below_parity;
          work_d       = work_q & ~ext.low_bit;
        end
      end
      StScanRight: begin
        if (!ext.nonzero) begin
          left_below_d  = left_below_q ^ (^left_q);
          right_below_d = right_below_q ^ (^right_q);
          chunk_d       = chunk_q + ChunkPosW'(1);
          state_d       = StFinish;
        end else if (right_found_q == oed_pkg::MaxFound) begin
          ovf_d   = 1'b1;
          chunk_d = chunk_q + ChunkPosW'(1);
          state_d = StFinish;
        end else begin
          pos_d[{1'b1, right_found_q[0]}] = found_pos;
          right_found_d = right_found_q + oed_pkg::CountW'(1);
          parity_d      = parity_q ^ right_below_q ^ ext.below_parity;
          work_d        = work_q & ~ext.low_bit;
        end
      end
      StFinish: begin
        if (!last_q) begin
          state_d = StIdle;
        end else if (out_free) begin
          // Load the result and start a fresh pair.
          out_valid_d   = 1'b1;
          diff_count_d  = ovf_q ? oed_pkg::OverflowCount : left_found_q;
          out_pos_d     = pos_q;
          odd_d         = ovf_q ? 1'b0 : parity_q;
          chunk_d       = '0;
          left_below_d  = 1'b0;
          right_below_d = 1'b0;
          left_found_d  = '0;
          right_found_d = '0;
          for (int i = 0; i < 4; i++) begin
            pos_d[i] = '0;
          end
          parity_d = 1'b0;
          ovf_d    = 1'b0;
          state_d  = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // Control and pair state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= StIdle;
      chunk_q       <= '0;
      left_below_q  <= 1'b0;
      right_below_q <= 1'b0;
      left_found_q  <= '0;
      right_found_q <= '0;
      for (int i = 0; i < 4; i++) begin
        pos_q[i] <= '0;
      end
      parity_q    <= 1'b0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q       <= state_d;
      chunk_q       <= chunk_d;
      left_below_q  <= left_below_d;
      right_below_q <= right_below_d;
      left_found_q  <= left_found_d;
      right_found_q <= right_found_d;
      pos_q         <= pos_d;
      parity_q      <= parity_d;
      ovf_q         <= ovf_d;
      out_valid_q   <= out_valid_d;
    end
  end

  // Chunk and result payload.
  always_ff @(posedge clk_i) begin
    left_q       <= left_d;
    right_q      <= right_d;
    work_q       <= work_d;
    last_q       <= last_d;
    diff_count_q <= diff_count_d;
    out_pos_q    <= out_pos_d;
    odd_q        <= odd_d;
  end

  assign out_valid_o       = out_valid_q;
  assign diff_count_o      = diff_count_q;
  assign left_first_o      = out_pos_q[0];
  assign left_second_o     = out_pos_q[1];
  assign right_first_o     = out_pos_q[2];
  assign right_second_o    = out_pos_q[3];
  assign odd_permutation_o = odd_q;

endmodule

// ----- rtl/oed_extract.sv -----
// Shared extractor: lowest set bit of a work vector and parity of the side bits below it.
module oed_extract (
  input  logic [oed_pkg::ChunkW-1:0] work_i,
  input  logic [oed_pkg::ChunkW-1:0] side_i,
  output oed_pkg::ext_res_t          res_o
);

  logic [oed_pkg::ChunkW-1:0]  low_bit;
  logic [oed_pkg::ChunkW-1:0]  mask_below;
  logic [oed_pkg::BitIdxW-1:0] index;

  // Isolate the lowest set bit and build the mask of the bits under it.
  assign low_bit    = work_i & (~work_i + oed_pkg::ChunkW'(1));
  assign mask_below = low_bit - oed_pkg::ChunkW'(1);

  // Encode the one-hot bit into its index: each index bit ORs the positions that carry it.
  always_comb begin
    index = '0;
    for (int b = 0; b < oed_pkg::BitIdxW; b++) begin
      for (int i = 0; i < oed_pkg::ChunkW; i++) begin
        if (((i >> b) & 1) == 1) begin
          index[b] = index[b] | low_bit[i];
        end
      end
    end
  end

  assign res_o.nonzero      = |work_i;
  assign res_o.index        = index;
  assign res_o.low_bit      = low_bit;
  assign res_o.below_parity = ^(side_i & mask_below);

endmodule
